[hdl/nirpd_pkg.sv]
// Shared types and constants for the NEC infrared pulse decoder.
// Used by every module in the hdl folder; it has no dependencies of its own.
package nirpd_pkg;

    localparam int DURATION_BITS_DEF = 16;
    localparam int DUR_W             = 16;
    localparam int CFG_W             = 16;
    localparam int CFG_IDX_W         = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE_MAX  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE_MIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE_MAX    = 3'd7;

    // Values after reset, in microseconds.
    localparam logic [CFG_W-1:0] HEADER_MARK_MIN_RST  = 16'd8500;
    localparam logic [CFG_W-1:0] HEADER_MARK_MAX_RST  = 16'd9500;
    localparam logic [CFG_W-1:0] HEADER_SPACE_MIN_RST = 16'd4000;
    localparam logic [CFG_W-1:0] HEADER_SPACE_MAX_RST = 16'd5000;
    localparam logic [CFG_W-1:0] SHORT_PULSE_MIN_RST  = 16'd400;
    localparam logic [CFG_W-1:0] SHORT_PULSE_MAX_RST  = 16'd700;
    localparam logic [CFG_W-1:0] ONE_SPACE_MIN_RST    = 16'd1500;
    localparam logic [CFG_W-1:0] ONE_SPACE_MAX_RST    = 16'd2000;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef struct packed {
        logic             pulse_level;
        logic [DUR_W-1:0] pulse_duration;
        logic             last_pulse;
    } nirpd_pulse_t;

    typedef struct packed {
        logic       frame_valid;
        logic [7:0] address;
        logic [7:0] command;
    } nirpd_result_t;

    typedef struct packed {
        logic [CFG_W-1:0] header_mark_min;
        logic [CFG_W-1:0] header_mark_max;
        logic [CFG_W-1:0] header_space_min;
        logic [CFG_W-1:0] header_space_max;
        logic [CFG_W-1:0] short_pulse_min;
        logic [CFG_W-1:0] short_pulse_max;
        logic [CFG_W-1:0] one_space_min;
        logic [CFG_W-1:0] one_space_max;
    } nirpd_cfg_t;

    // Outcome of the window checks on one pulse.
    typedef struct packed {
        logic level;
        logic header_mark_ok;
        logic header_space_ok;
        logic short_ok;
        logic one_ok;
        logic last;
    } nirpd_flags_t;

endpackage

[hdl/nirpd_pulse_check.sv]
// Window comparators that classify one registered pulse.
// Depends on nirpd_pkg for the pulse, configuration and flag types.
module nirpd_pulse_check #(
    parameter int DURATION_BITS = nirpd_pkg::DURATION_BITS_DEF
) (
    input  nirpd_pkg::nirpd_pulse_t pulse,
    input  nirpd_pkg::nirpd_cfg_t   cfg,
    output nirpd_pkg::nirpd_flags_t flags
);
    import nirpd_pkg::*;

    localparam int CMP_W = (DURATION_BITS > CFG_W) ? DURATION_BITS : CFG_W;

    logic [CMP_W-1:0] dur;

    function automatic logic in_window(input logic [CMP_W-1:0] d,
                                       input logic [CFG_W-1:0] lo,
                                       input logic [CFG_W-1:0] hi);
        return (d > CMP_W'(lo)) && (d < CMP_W'(hi));
    endfunction

    // Only the low DURATION_BITS bits of the duration take part in the checks.
    assign dur = CMP_W'(pulse.pulse_duration) & ~({CMP_W{1'b1}} << DURATION_BITS);

    always_comb begin
        flags.level           = pulse.pulse_level;
        flags.last            = pulse.last_pulse;
        flags.header_mark_ok  = in_window(dur, cfg.header_mark_min, cfg.header_mark_max);
        flags.header_space_ok = in_window(dur, cfg.header_space_min, cfg.header_space_max);
        flags.short_ok        = in_window(dur, cfg.short_pulse_min, cfg.short_pulse_max);
        flags.one_ok          = in_window(dur, cfg.one_space_min, cfg.one_space_max);
    end

endmodule

[hdl/nirpd_frame.sv]
// Frame sequencer: phase tracking, bit shift register and the final validity check.
// Depends on nirpd_pkg for the flag and result types.
module nirpd_frame (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  nirpd_pkg::nirpd_flags_t  flags,
    output logic                     result_fire,
    output nirpd_pkg::nirpd_result_t result
);
    import nirpd_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR_MARK  = 4'b0001,
        PH_HDR_SPACE = 4'b0010,
        PH_BIT_MARK  = 4'b0100,
        PH_BIT_SPACE = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next, phase_adv;
    logic [31:0] shift_reg, shift_next, shift_adv;
    logic        pend_reg, pend_next, pend_adv;
    logic        failed_reg, failed_next, failed_adv;
    logic        valid;

    always_comb begin
        phase_adv  = phase_reg;
        shift_adv  = shift_reg;
        pend_adv   = pend_reg;
        failed_adv = failed_reg;
        case (phase_reg)
            PH_HDR_MARK: begin
                if (flags.level || !flags.header_mark_ok) begin
                    failed_adv = 1'b1;
                end
                phase_adv = PH_HDR_SPACE;
            end
            PH_HDR_SPACE: begin
                if (!flags.level || !flags.header_space_ok) begin
                    failed_adv = 1'b1;
                end
                phase_adv = PH_BIT_MARK;
            end
            PH_BIT_MARK: begin
                pend_adv  = !flags.level && flags.short_ok;
                phase_adv = PH_BIT_SPACE;
            end
            default: begin
                // The level of a bit space is not checked, only its length.
                if (!failed_reg) begin
                    if (!pend_reg) begin
                        failed_adv = 1'b1;
                    end else if (flags.short_ok) begin
                        shift_adv = {1'b0, shift_reg[31:1]};
                    end else if (flags.one_ok) begin
                        shift_adv = {1'b1, shift_reg[31:1]};
                    end else begin
                        failed_adv = 1'b1;
                    end
                end
                phase_adv = PH_BIT_MARK;
            end
        endcase
    end

    // A frame that ends on its header mark is too short to be valid.
    assign valid = !failed_adv && (phase_adv != PH_HDR_SPACE)
                   && (shift_adv[7:0] == (~shift_adv[15:8] & BYTE_MASK))
                   && (shift_adv[23:16] == (~shift_adv[31:24] & BYTE_MASK));

    assign result_fire        = step && flags.last;
    assign result.frame_valid = valid;
    assign result.address     = valid ? shift_adv[7:0] : 8'd0;
    assign result.command     = valid ? shift_adv[23:16] : 8'd0;

    always_comb begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        pend_next   = pend_reg;
        failed_next = failed_reg;
        if (step) begin
            if (flags.last) begin
                phase_next  = PH_HDR_MARK;
                shift_next  = '0;
                pend_next   = 1'b0;
                failed_next = 1'b0;
            end else begin
                phase_next  = phase_adv;
                shift_next  = shift_adv;
                pend_next   = pend_adv;
                failed_next = failed_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR_MARK;
            shift_reg  <= '0;
            pend_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            pend_reg   <= pend_next;
            failed_reg <= failed_next;
        end
    end

endmodule

[hdl/nec_ir_pulse_decoder.sv]
// Decodes NEC infrared frames from captured pulses, one pulse per transfer, and gives one
// result per frame on the transfer that carries the last-pulse mark. A pulse is taken every
// clock cycle while results are being drained; each pulse passes through an input register,
// the window compares and frame update, and a result register. A result is written to the
// result register when its final pulse leaves the input register, which waits while the
// result register is full and not being taken. Throughput stalls only when the result
// register is full and not being taken. The eight window registers reset to standard NEC
// timings and should be written only while no frame is in flight.
// Depends on nirpd_pkg, nirpd_pulse_check and nirpd_frame.
module nec_ir_pulse_decoder #(
    parameter int DURATION_BITS = nirpd_pkg::DURATION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  nirpd_pkg::nirpd_pulse_t              s_payload,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output nirpd_pkg::nirpd_result_t             m_payload,
    input  logic                                 cfg_wr_en,
    input  logic [nirpd_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [nirpd_pkg::CFG_W-1:0]          cfg_wr_data
);
    import nirpd_pkg::*;

    nirpd_cfg_t    cfg_reg, cfg_next;
    nirpd_pulse_t  in_data_reg;
    logic          in_valid_reg, in_valid_next;
    nirpd_result_t out_data_reg;
    logic          out_valid_reg, out_valid_next;
    nirpd_flags_t  flags;
    nirpd_result_t result;
    logic          result_fire;
    logic          advance;

    // The staged pulse moves on once the result register can take whatever it produces.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_HEADER_MARK_MIN:  cfg_next.header_mark_min  = cfg_wr_data;
                REG_HEADER_MARK_MAX:  cfg_next.header_mark_max  = cfg_wr_data;
                REG_HEADER_SPACE_MIN: cfg_next.header_space_min = cfg_wr_data;
                REG_HEADER_SPACE_MAX: cfg_next.header_space_max = cfg_wr_data;
                REG_SHORT_PULSE_MIN:  cfg_next.short_pulse_min  = cfg_wr_data;
                REG_SHORT_PULSE_MAX:  cfg_next.short_pulse_max  = cfg_wr_data;
                REG_ONE_SPACE_MIN:    cfg_next.one_space_min    = cfg_wr_data;
                REG_ONE_SPACE_MAX:    cfg_next.one_space_max    = cfg_wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && result_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_mark_min  <= HEADER_MARK_MIN_RST;
            cfg_reg.header_mark_max  <= HEADER_MARK_MAX_RST;
            cfg_reg.header_space_min <= HEADER_SPACE_MIN_RST;
            cfg_reg.header_space_max <= HEADER_SPACE_MAX_RST;
            cfg_reg.short_pulse_min  <= SHORT_PULSE_MIN_RST;
            cfg_reg.short_pulse_max  <= SHORT_PULSE_MAX_RST;
            cfg_reg.one_space_min    <= ONE_SPACE_MIN_RST;
            cfg_reg.one_space_max    <= ONE_SPACE_MAX_RST;
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
        if (advance && result_fire) begin
            out_data_reg <= result;
        end
    end

    nirpd_pulse_check #(
        .DURATION_BITS(DURATION_BITS)
    ) u_pulse_check (
        .pulse (in_data_reg),
        .cfg   (cfg_reg),
        .flags (flags)
    );

    nirpd_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .flags       (flags),
        .result_fire (result_fire),
        .result      (result)
    );

endmodule
